[sv/hbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the high-pass biquad front end
// Coefficient set, register indexes, fixed-point widths and the rounding and
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned EmphW   = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OpW     = 25;
  localparam int unsigned ProdW   = 2 * OpW;
  localparam int unsigned AccW    = 52;
  localparam int unsigned DelayW  = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_EMPH = 3'd5
  } reg_idx_e;

  localparam logic signed [CoefW-1:0] ResetB0   = 24'sd1042769;
  localparam logic signed [CoefW-1:0] ResetB1   = -24'sd2085537;
  localparam logic signed [CoefW-1:0] ResetB2   = 24'sd1042769;
  localparam logic signed [CoefW-1:0] ResetA1   = -24'sd2085505;
  localparam logic signed [CoefW-1:0] ResetA2   = 24'sd1036994;
  localparam logic        [EmphW-1:0] ResetEmph = 21'd713032;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
    logic        [EmphW-1:0] emph;
  } coef_set_t;

  // Round a Q40 value to Q20 (half toward plus infinity) and clamp to 24 bits.
  function automatic logic signed [CoefW-1:0] round_sat24(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] sh;
    logic signed [CoefW-1:0] r;
    t  = v + 52'sd524288;
    sh = t >>> 20;
    if (sh > 52'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (sh < -52'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = sh[CoefW-1:0];
    end
    return r;
  endfunction

  // Clamp an accumulator value to the 48-bit delay range.
  function automatic logic signed [DelayW-1:0] sat48(input logic signed [AccW-1:0] v);
    logic signed [DelayW-1:0] r;
    if (v > 52'sd140737488355327) begin
      r = {1'b0, {(DelayW-1){1'b1}}};
    end else if (v < -52'sd140737488355328) begin
      r = {1'b1, {(DelayW-1){1'b0}}};
    end else begin
      r = v[DelayW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/hbp_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_cfg: coefficient register file
// Holds the five biquad coefficients and the pre-emphasis factor, written
// through a plain indexed write port. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hbp_cfg
  import hbp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_data_i,
  output coef_set_t               coef_o
);

  coef_set_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0   <= ResetB0;
      coef_q.b1   <= ResetB1;
      coef_q.b2   <= ResetB2;
      coef_q.a1   <= ResetA1;
      coef_q.a2   <= ResetA2;
      coef_q.emph <= ResetEmph;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:   coef_q.b0   <= cfg_data_i;
        REG_B1:   coef_q.b1   <= cfg_data_i;
        REG_B2:   coef_q.b2   <= cfg_data_i;
        REG_A1:   coef_q.a1   <= cfg_data_i;
        REG_A2:   coef_q.a2   <= cfg_data_i;
        REG_EMPH: coef_q.emph <= cfg_data_i[EmphW-1:0];
        default:  ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

[sv/hbp_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_mul: shared signed multiplier
// One 25 x 25 signed multiplier with a registered product, time-shared by the
// sequencer for all six products of a sample.
// ----------------------------------------------------------------------------
module hbp_mul
  import hbp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [OpW-1:0]   op_a_i,
  input  wire logic signed [OpW-1:0]   op_b_i,
  output logic signed [ProdW-1:0]      prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[sv/highpass_biquad_preemphasis_core.sv]
// Sequence: an accepted word steps through B0, F, A1, D1, B2, D2 and EMP to the output.
// Flow: a new word is taken only back in idle, as the six products share one
// multiplier under the sequencer; a finished result may wait in the output register
// while the next word is already taken.
// Reset: rst_ni clears the sequencer, output valid and filter state, and loads the
// default 20 Hz / 16 kHz coefficients.
`default_nettype none
// ----------------------------------------------------------------------------
// highpass_biquad_preemphasis_core: high-pass biquad with pre-emphasis
// Direct form II transposed biquad followed by a first-order pre-emphasis
// stage, computed on one shared multiplier and a 52-bit accumulator.
// ----------------------------------------------------------------------------
module highpass_biquad_preemphasis_core
  import hbp_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [CoefW-1:0]           cfg_data_i,
  input  wire logic                       pcm_valid_i,
  output logic                            pcm_stall_o,
  input  wire logic signed [SampleW-1:0]  pcm_sample_i,
  output logic                            emph_valid_o,
  input  wire logic                       emph_stall_i,
  output logic signed [CoefW-1:0]         emphasized_sample_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_F,
    S_A1,
    S_D1,
    S_B2,
    S_D2,
    S_EMP
  } seq_e;

  seq_e                     state_q;
  coef_set_t                coef;
  logic signed [SampleW-1:0] sample_q;
  logic signed [CoefW-1:0]  f_q;
  logic signed [CoefW-1:0]  prev_q;
  logic signed [DelayW-1:0] d1_q;
  logic signed [DelayW-1:0] d2_q;
  logic signed [AccW-1:0]   acc_q;
  logic                     out_valid_q;
  logic signed [CoefW-1:0]  out_q;

  logic signed [OpW-1:0]    op_a;
  logic signed [OpW-1:0]    op_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [AccW-1:0]   prod_ext;
  logic signed [OpW-1:0]    x_op;
  logic signed [OpW-1:0]    f_op;
  logic                     mul_en;
  logic                     out_free;
  logic                     accept;

  hbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  hbp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign pcm_stall_o = (state_q != S_IDLE);
  assign accept      = pcm_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !emph_stall_i;
  assign mul_en      = (state_q != S_EMP);
  assign prod_ext    = AccW'(prod);

  // The sample enters the datapath as Q20, i.e. times 32.
  assign x_op = {{(OpW-SampleW-5){sample_q[SampleW-1]}}, sample_q, 5'd0};
  assign f_op = OpW'(f_q);

  always_comb begin
    op_a = OpW'(coef.b0);
    op_b = x_op;
    case (state_q)
      S_B0: begin
        op_a = OpW'(coef.b0);
        op_b = x_op;
      end
      S_F: begin
        op_a = OpW'(coef.b1);
        op_b = x_op;
      end
      S_A1: begin
        op_a = OpW'(coef.a1);
        op_b = f_op;
      end
      S_D1: begin
        op_a = OpW'(coef.b2);
        op_b = x_op;
      end
      S_B2: begin
        op_a = OpW'(coef.a2);
        op_b = f_op;
      end
      S_D2: begin
        // The emphasis factor is unsigned, so it is zero-extended.
        op_a = {{(OpW-EmphW){1'b0}}, coef.emph};
        op_b = OpW'(prev_q);
      end
      default: begin
        op_a = OpW'(coef.b0);
        op_b = x_op;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      prev_q      <= '0;
      sample_q    <= '0;
      f_q         <= '0;
      acc_q       <= '0;
      out_q       <= '0;
    end else begin
      if ((state_q == S_EMP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !emph_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sample_q <= pcm_sample_i;
            state_q  <= S_B0;
          end
        end
        S_B0: state_q <= S_F;
        S_F: begin
          f_q     <= round_sat24(prod_ext + AccW'(d1_q));
          state_q <= S_A1;
        end
        S_A1: begin
          acc_q   <= prod_ext + AccW'(d2_q);
          state_q <= S_D1;
        end
        S_D1: begin
          d1_q    <= sat48(acc_q - prod_ext);
          state_q <= S_B2;
        end
        S_B2: begin
          acc_q   <= prod_ext;
          state_q <= S_D2;
        end
        S_D2: begin
          d2_q    <= sat48(acc_q - prod_ext);
          state_q <= S_EMP;
        end
        S_EMP: begin
          // Wait here until the output register can take the new result.
          if (out_free) begin
            out_q       <= round_sat24({{(AccW-CoefW-20){f_q[CoefW-1]}}, f_q, 20'd0}
                                       - prod_ext);
            prev_q      <= f_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign emph_valid_o        = out_valid_q;
  assign emphasized_sample_o = out_q;

endmodule

`default_nettype wire
